// ===== rtl/handheld_bus_address_decoder_top_defines.svh =====
// Assertion macros shared by the bus decoder RTL.
`ifndef HANDHELD_BUS_ADDRESS_DECODER_TOP_DEFINES_SVH
`define HANDHELD_BUS_ADDRESS_DECODER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked outside reset only.
`define HBAD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked on every edge, reset included.
`define HBAD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define HBAD_ASSERT(lbl, prop, msg)
`define HBAD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/hbad_pkg.sv =====
// Types, codes and address map of the handheld bus decoder.
package hbad_pkg;

  localparam int WORK_RAM_BYTES = 8192;
  localparam int HIGH_RAM_BYTES = 128;
  localparam int WRAM_AW = $clog2(WORK_RAM_BYTES);
  localparam int HRAM_AW = $clog2(HIGH_RAM_BYTES);

  // Request types
  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_IRQ   = 2'd2;

  // Routes
  localparam logic [1:0] ROUTE_NONE  = 2'd0;
  localparam logic [1:0] ROUTE_CART  = 2'd1;
  localparam logic [1:0] ROUTE_VIDEO = 2'd2;
  localparam logic [1:0] ROUTE_TIMER = 2'd3;

  // Address map
  localparam logic [15:0] BOOT_END   = 16'h0100;
  localparam logic [15:0] VRAM_LO    = 16'h8000;
  localparam logic [15:0] VRAM_HI    = 16'h9FFF;
  localparam logic [15:0] OAM_LO     = 16'hFE00;
  localparam logic [15:0] OAM_HI     = 16'hFE9F;
  localparam logic [15:0] WRAM_LO    = 16'hC000;
  localparam logic [15:0] ECHO_HI    = 16'hFDFF;
  localparam logic [15:0] IO_LO      = 16'hFF00;
  localparam logic [15:0] IO_HI      = 16'hFF7F;
  localparam logic [15:0] HRAM_LO    = 16'hFF80;
  localparam logic [15:0] HRAM_HI    = 16'hFFFE;
  localparam logic [15:0] ADDR_IE    = 16'hFFFF;
  localparam logic [15:0] ADDR_JOYP  = 16'hFF00;
  localparam logic [15:0] ADDR_SB    = 16'hFF01;
  localparam logic [15:0] ADDR_SC    = 16'hFF02;
  localparam logic [15:0] TIMER_LO   = 16'hFF04;
  localparam logic [15:0] TIMER_HI   = 16'hFF07;
  localparam logic [15:0] ADDR_IF    = 16'hFF0F;
  localparam logic [15:0] LCD_LO     = 16'hFF40;
  localparam logic [15:0] LCD_HI     = 16'hFF43;
  localparam logic [15:0] ADDR_LY    = 16'hFF44;
  localparam logic [15:0] ADDR_LYC   = 16'hFF45;
  localparam logic [15:0] ADDR_DMA   = 16'hFF46;
  localparam logic [15:0] PAL_LO     = 16'hFF47;
  localparam logic [15:0] PAL_HI     = 16'hFF49;
  localparam logic [15:0] ADDR_BOOT  = 16'hFF50;

  localparam logic [7:0] JOYP_RESET = 8'hCF;
  localparam logic [7:0] JOYP_KEEP  = 8'hCF;
  localparam logic [7:0] JOYP_SEL   = 8'h30;
  localparam logic [7:0] IRQ_UNUSED = 8'hE0;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] bus_address;
    logic [7:0]  write_byte;
    logic [4:0]  irq_bits;
    logic        cart_claims;
    logic [7:0]  cart_byte;
    logic [7:0]  video_byte;
    logic [7:0]  timer_byte;
    logic [7:0]  boot_byte;
    logic [3:0]  button_nibble;
    logic [3:0]  pad_nibble;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [1:0] route;
    logic       route_is_write;
    logic [7:0] flag_bits;
    logic [7:0] enable_bits;
  } out_t;

  typedef struct packed {
    logic [7:0] joypad_select;
    logic [7:0] serial_data;
    logic [7:0] serial_control;
    logic [7:0] irq_flags;
    logic [7:0] irq_enable;
    logic [7:0] dma_source;
    logic [7:0] boot_map;
  } regs_t;

  typedef struct packed {
    logic               wram_we;
    logic               hram_we;
    logic [WRAM_AW-1:0] waddr;
    logic [7:0]         wdata;
  } mem_wr_t;

endpackage

// ===== rtl/hbad_ram.sv =====
// Single-port-write, registered-read RAM used for work and high RAM.
module hbad_ram #(
  parameter int ADDR_W = 7,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/hbad_decode.sv =====
// Address decode, register update and read data selection for one request.
module hbad_decode (
  input  hbad_pkg::in_t     item,
  input  hbad_pkg::regs_t   regs,
  input  logic [7:0]        wram_rd,
  input  logic [7:0]        hram_rd,
  output hbad_pkg::regs_t   regs_nxt,
  output hbad_pkg::mem_wr_t mem_wr,
  output hbad_pkg::out_t    result
);

  logic [15:0] a;
  logic        wr;
  logic [7:0]  rd;
  logic [1:0]  route;
  logic [7:0]  joyp_rd;
  logic [7:0]  sel;
  logic        video_reg;

  assign a   = item.bus_address;
  assign wr  = (item.req_type == hbad_pkg::REQ_WRITE);
  assign sel = regs.joypad_select;

  always_comb begin
    if ((sel & hbad_pkg::JOYP_SEL) == hbad_pkg::JOYP_SEL) begin
      joyp_rd = sel | 8'h0F;
    end else if ((sel & hbad_pkg::JOYP_SEL) == 8'h00) begin
      joyp_rd = {sel[7:4], item.button_nibble & item.pad_nibble};
    end else if (!sel[5]) begin
      joyp_rd = {sel[7:4], item.button_nibble};
    end else begin
      joyp_rd = {sel[7:4], item.pad_nibble};
    end
  end

  // Line counter is routed for reads only
  assign video_reg = (a >= hbad_pkg::LCD_LO && a <= hbad_pkg::LCD_HI) ||
                     (a == hbad_pkg::ADDR_LY && !wr) ||
                     (a == hbad_pkg::ADDR_LYC) ||
                     (a >= hbad_pkg::PAL_LO && a <= hbad_pkg::PAL_HI);

  always_comb begin
    regs_nxt       = regs;
    rd             = 8'h00;
    route          = hbad_pkg::ROUTE_NONE;
    mem_wr.wram_we = 1'b0;
    mem_wr.hram_we = 1'b0;
    mem_wr.waddr   = a[hbad_pkg::WRAM_AW-1:0];
    mem_wr.wdata   = item.write_byte;
    if (item.req_type == hbad_pkg::REQ_IRQ) begin
      regs_nxt.irq_flags = regs.irq_flags | {3'b000, item.irq_bits};
    end else if (item.req_type == hbad_pkg::REQ_READ || wr) begin
      if (a < hbad_pkg::BOOT_END && !regs.boot_map[0]) begin
        rd = item.boot_byte;
      end else if (item.cart_claims) begin
        route = hbad_pkg::ROUTE_CART;
        rd    = item.cart_byte;
      end else if ((a >= hbad_pkg::VRAM_LO && a <= hbad_pkg::VRAM_HI) ||
                   (a >= hbad_pkg::OAM_LO && a <= hbad_pkg::OAM_HI)) begin
        route = hbad_pkg::ROUTE_VIDEO;
        rd    = item.video_byte;
      end else if (a >= hbad_pkg::WRAM_LO && a <= hbad_pkg::ECHO_HI) begin
        mem_wr.wram_we = wr;
        rd             = wram_rd;
      end else if (a >= hbad_pkg::IO_LO && a <= hbad_pkg::IO_HI) begin
        if (a >= hbad_pkg::TIMER_LO && a <= hbad_pkg::TIMER_HI) begin
          route = hbad_pkg::ROUTE_TIMER;
          rd    = item.timer_byte;
        end else if (video_reg) begin
          route = hbad_pkg::ROUTE_VIDEO;
          rd    = item.video_byte;
        end else if (a == hbad_pkg::ADDR_JOYP) begin
          rd = joyp_rd;
          if (wr) begin
            regs_nxt.joypad_select = (item.write_byte & hbad_pkg::JOYP_SEL) |
                                     (sel & hbad_pkg::JOYP_KEEP);
          end
        end else if (a == hbad_pkg::ADDR_SB) begin
          rd = regs.serial_data;
          if (wr) regs_nxt.serial_data = item.write_byte;
        end else if (a == hbad_pkg::ADDR_SC) begin
          rd = regs.serial_control;
          if (wr) regs_nxt.serial_control = item.write_byte;
        end else if (a == hbad_pkg::ADDR_IF) begin
          rd = hbad_pkg::IRQ_UNUSED | regs.irq_flags;
          if (wr) regs_nxt.irq_flags = item.write_byte;
        end else if (a == hbad_pkg::ADDR_DMA) begin
          rd = regs.dma_source;
          if (wr) regs_nxt.dma_source = item.write_byte;
        end else if (a == hbad_pkg::ADDR_BOOT) begin
          rd = regs.boot_map;
          if (wr) regs_nxt.boot_map = item.write_byte;
        end
      end else if (a >= hbad_pkg::HRAM_LO && a <= hbad_pkg::HRAM_HI) begin
        mem_wr.hram_we = wr;
        rd             = hram_rd;
      end else if (a == hbad_pkg::ADDR_IE) begin
        rd = hbad_pkg::IRQ_UNUSED | regs.irq_enable;
        if (wr) regs_nxt.irq_enable = item.write_byte;
      end
    end else begin
      route = hbad_pkg::ROUTE_NONE;
    end
  end

  assign result.read_data      = (item.req_type == hbad_pkg::REQ_READ) ? rd : 8'h00;
  assign result.route          = route;
  assign result.route_is_write = wr && (route != hbad_pkg::ROUTE_NONE);
  assign result.flag_bits      = regs_nxt.irq_flags;
  assign result.enable_bits    = regs_nxt.irq_enable;

endmodule

// ===== rtl/handheld_bus_address_decoder_top.sv =====
// Top level of the handheld bus decoder: request stage, RAMs, result register.
//
//  channel  | ports                          | payload
//  ---------+--------------------------------+--------------
//  request  | in_valid, in_ready, in_data    | hbad_pkg::in_t
//  result   | out_valid, out_ready, out_data | hbad_pkg::out_t
//
// One request per cycle sustained while out_ready stays high; each passes
// through the request stage, where the decode runs, to the result register,
// the RAM read port registering at acceptance. After reset a clearing pass
// zeroes both RAMs, in_ready staying low throughout. A stalled result holds
// the request stage, which then holds in_ready low until the result is taken.
`include "handheld_bus_address_decoder_top_defines.svh"

module handheld_bus_address_decoder_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  hbad_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output hbad_pkg::out_t out_data
);

  localparam int WAW = hbad_pkg::WRAM_AW;
  localparam int HAW = hbad_pkg::HRAM_AW;

  logic              clr_busy_r;
  logic [WAW-1:0]    clr_cnt_r;
  logic              s1_v_r;
  hbad_pkg::in_t     s1_item_r;
  logic              out_valid_r;
  hbad_pkg::out_t    out_data_r;
  hbad_pkg::regs_t   regs_r;
  hbad_pkg::regs_t   regs_nxt;
  hbad_pkg::mem_wr_t mem_wr;
  hbad_pkg::out_t    result;
  logic              fwd_wram_r;
  logic              fwd_hram_r;
  logic [7:0]        fwd_data_r;
  logic              s1_adv;
  logic              s1_fire;
  logic              in_acc;
  logic              wram_we;
  logic              hram_we;
  logic [WAW-1:0]    wram_waddr;
  logic [HAW-1:0]    hram_waddr;
  logic [7:0]        ram_wdata;
  logic [7:0]        wram_q;
  logic [7:0]        hram_q;
  logic [7:0]        wram_rd;
  logic [7:0]        hram_rd;

  assign s1_adv   = !out_valid_r || out_ready;
  assign s1_fire  = s1_v_r && s1_adv;
  assign in_ready = !clr_busy_r && (!s1_v_r || s1_adv);
  assign in_acc   = in_valid && in_ready;

  // Clearing pass: sweep every work RAM entry, high RAM folded onto low bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (&clr_cnt_r) clr_busy_r <= 1'b0;
    end
  end

  assign wram_we    = clr_busy_r || (s1_fire && mem_wr.wram_we);
  assign hram_we    = clr_busy_r || (s1_fire && mem_wr.hram_we);
  assign wram_waddr = clr_busy_r ? clr_cnt_r : mem_wr.waddr;
  assign hram_waddr = clr_busy_r ? clr_cnt_r[HAW-1:0] : mem_wr.waddr[HAW-1:0];
  assign ram_wdata  = clr_busy_r ? 8'h00 : mem_wr.wdata;

  hbad_ram #(.ADDR_W(WAW), .DATA_W(8)) u_wram (
    .clk   (clk),
    .we    (wram_we),
    .waddr (wram_waddr),
    .wdata (ram_wdata),
    .re    (in_acc),
    .raddr (in_data.bus_address[WAW-1:0]),
    .rdata (wram_q)
  );

  hbad_ram #(.ADDR_W(HAW), .DATA_W(8)) u_hram (
    .clk   (clk),
    .we    (hram_we),
    .waddr (hram_waddr),
    .wdata (ram_wdata),
    .re    (in_acc),
    .raddr (in_data.bus_address[HAW-1:0]),
    .rdata (hram_q)
  );

  // Forward a write retiring on the same edge that the next request reads
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_wram_r <= 1'b0;
      fwd_hram_r <= 1'b0;
    end else if (in_acc) begin
      fwd_wram_r <= s1_fire && mem_wr.wram_we &&
                    (mem_wr.waddr == in_data.bus_address[WAW-1:0]);
      fwd_hram_r <= s1_fire && mem_wr.hram_we &&
                    (mem_wr.waddr[HAW-1:0] == in_data.bus_address[HAW-1:0]);
    end else if (s1_fire) begin
      // drop the flags once the stage empties
      fwd_wram_r <= 1'b0;
      fwd_hram_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) fwd_data_r <= mem_wr.wdata;
  end

  assign wram_rd = fwd_wram_r ? fwd_data_r : wram_q;
  assign hram_rd = fwd_hram_r ? fwd_data_r : hram_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) s1_item_r <= in_data;
  end

  hbad_decode u_decode (
    .item     (s1_item_r),
    .regs     (regs_r),
    .wram_rd  (wram_rd),
    .hram_rd  (hram_rd),
    .regs_nxt (regs_nxt),
    .mem_wr   (mem_wr),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.joypad_select  <= hbad_pkg::JOYP_RESET;
      regs_r.serial_data    <= 8'h00;
      regs_r.serial_control <= 8'h00;
      regs_r.irq_flags      <= 8'h00;
      regs_r.irq_enable     <= 8'h00;
      regs_r.dma_source     <= 8'h00;
      regs_r.boot_map       <= 8'h00;
    end else if (s1_fire) begin
      regs_r <= regs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) out_data_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `HBAD_ASSERT_ALWAYS(a_no_req_in_clear, clr_busy_r |-> !in_ready, "request taken during RAM clear")
  `HBAD_ASSERT(a_stage_to_out, s1_fire |=> out_valid_r, "retired request gave no result")
  `HBAD_ASSERT(a_fwd_needs_stage, (fwd_wram_r || fwd_hram_r) |-> s1_v_r, "forward flag without request")
  `HBAD_ASSERT(a_fwd_one_ram, !(fwd_wram_r && fwd_hram_r), "forward to both RAMs at once")
  `HBAD_ASSERT(a_strobe_routed, (out_valid_r && out_data_r.route == hbad_pkg::ROUTE_NONE) |-> !out_data_r.route_is_write, "write strobe with no route")

endmodule
